[sv/msst_pkg.sv]
// Shared types and constants for the multi-store slot table.
// Holds command codes, status codes and the control/status structs that
// join the controller to the datapath. Depends on nothing.
package msst_pkg;

	localparam int CMD_W    = 3;
	localparam int ID_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 4;
	localparam int SIZE_W   = 5;
	localparam int STATUS_W = 3;
	localparam int MASK_W   = 8;
	localparam int COUNT_W  = 8;

	localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD_FREE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ADD_AT   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLR_VAL  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLR_AT   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_FIND     = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_ID    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OCCUPIED  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                load;
		logic                set_status;
		logic [STATUS_W-1:0] status_code;
		logic                create_start;
		logic                clear_step;
		logic                create_done;
		logic                scan_start;
		logic                scan_en;
		logic                poke_start;
		logic                poke_exec;
		logic                out_load;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             bad_size;
		logic             full;
		logic             bad_id;
		logic             bad_index;
		logic             no_stores;
		logic             clear_last;
		logic             scan_busy;
		logic             found;
		logic             occupied;
	} dp_stat_t;

endpackage

[sv/msst_datapath.sv]
// Datapath of the multi-store slot table: latched command fields, the store
// length memory, the slot memory, the scan pipeline and the result registers.
// Depends on msst_pkg; driven by msst_ctrl through ctl_cmd_t.
module msst_datapath #(
	parameter int NUM_STORES = 8,
	parameter int MAX_SLOTS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [msst_pkg::CMD_W-1:0]        in_cmd,
	input  logic [msst_pkg::ID_W-1:0]         in_store_id,
	input  logic [msst_pkg::VALUE_W-1:0]      in_value,
	input  logic [msst_pkg::INDEX_W-1:0]      in_slot_index,
	input  logic [msst_pkg::SIZE_W-1:0]       in_new_size,
	input  msst_pkg::ctl_cmd_t                ctl,
	output msst_pkg::dp_stat_t                stat,
	output logic [msst_pkg::STATUS_W-1:0]     out_status,
	output logic [msst_pkg::ID_W-1:0]         out_created_id,
	output logic [msst_pkg::MASK_W-1:0]       out_match_mask,
	output logic [msst_pkg::COUNT_W-1:0]      out_match_count
);
	import msst_pkg::*;

	localparam int DEPTH = NUM_STORES * MAX_SLOTS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = (NUM_STORES > 1) ? $clog2(NUM_STORES) : 1;
	localparam int SW    = $clog2(NUM_STORES + 1);
	localparam int LW    = $clog2(MAX_SLOTS + 1);
	localparam logic [AW-1:0] SLOTS_A   = AW'(MAX_SLOTS);
	localparam logic [LW-1:0] LAST_SLOT = LW'(MAX_SLOTS - 1);

	// Latched command fields.
	logic [CMD_W-1:0]   cmd_q;
	logic [ID_W-1:0]    id_q;
	logic [VALUE_W-1:0] val_q;
	logic [INDEX_W-1:0] idx_q;
	logic [SIZE_W-1:0]  size_q;

	logic [SW-1:0]      made_q;

	logic [LW-1:0]      len_mem [NUM_STORES];
	logic [LW-1:0]      len_rd_q;
	logic [IW-1:0]      len_ra;

	logic [VALUE_W-1:0] slot_mem [DEPTH];
	logic [VALUE_W-1:0] slot_rd_q;
	logic [AW-1:0]      slot_ra;
	logic               slot_we;
	logic [AW-1:0]      slot_wa;
	logic [VALUE_W-1:0] slot_wd;

	// Scan issue stage and compare stage.
	logic [IW-1:0]      cur_st_q;
	logic [IW-1:0]      cur_st_d;
	logic [IW-1:0]      start_st;
	logic [LW-1:0]      sl_q;
	logic [LW-1:0]      cur_len_q;
	logic [AW-1:0]      addr_q;
	logic [AW-1:0]      row_q;
	logic               issue_q;
	logic               issue_fire;
	logic               row_end;
	logic               more;
	logic               vld_s1;
	logic [AW-1:0]      addr_s1;
	logic [IW-1:0]      st_s1;
	logic               found_q;
	logic               cmp_en;
	logic               find_hit;

	logic [IW-1:0]      mul_st;
	logic [AW-1:0]      mul_base;
	logic [31:0]        len_nxt;

	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     made_res_q;
	logic [MASK_W-1:0]   mask_q;
	logic [COUNT_W-1:0]  count_q;

	assign start_st   = (cmd_q == CMD_FIND) ? '0 : IW'(id_q);
	assign issue_fire = ctl.scan_en && issue_q;
	assign row_end    = (LW'(sl_q + 1'b1) == cur_len_q);
	assign more       = (cmd_q == CMD_FIND) && ((32'(cur_st_q) + 32'd1) < 32'(made_q));
	assign cmp_en     = ctl.scan_en && vld_s1;
	assign find_hit   = cmp_en && (cmd_q == CMD_FIND) && (slot_rd_q == val_q);

	always_comb begin
		if (ctl.create_start) begin
			mul_st = IW'(made_q);
		end else if (ctl.poke_start) begin
			mul_st = IW'(id_q);
		end else begin
			mul_st = start_st;
		end
	end

	assign mul_base = AW'(mul_st) * SLOTS_A;

	always_comb begin
		cur_st_d = cur_st_q;
		if (ctl.scan_start) begin
			cur_st_d = start_st;
		end else if (issue_fire && row_end && more) begin
			cur_st_d = cur_st_q + IW'(1);
		end
	end

	// The length of the following store is prefetched while the current one
	// is scanned, so a find steps from row to row without a bubble.
	assign len_nxt = 32'(cur_st_d) + 32'd1;

	always_comb begin
		if (ctl.load) begin
			len_ra = (in_cmd == CMD_FIND) ? '0 : IW'(in_store_id);
		end else if (len_nxt < 32'(NUM_STORES)) begin
			len_ra = IW'(len_nxt);
		end else begin
			len_ra = '0;
		end
	end

	assign slot_ra = ctl.poke_start ? AW'(mul_base + AW'(idx_q)) : addr_q;

	always_comb begin
		slot_we = 1'b0;
		slot_wa = addr_q;
		slot_wd = '0;
		if (ctl.clear_step) begin
			slot_we = 1'b1;
		end else if (ctl.poke_exec) begin
			if (cmd_q == CMD_ADD_AT) begin
				slot_we = (slot_rd_q == '0);
				slot_wd = val_q;
			end else begin
				slot_we = 1'b1;
			end
		end else if (cmp_en) begin
			slot_wa = addr_s1;
			if (cmd_q == CMD_ADD_FREE) begin
				slot_we = !found_q && (slot_rd_q == '0);
				slot_wd = val_q;
			end else if (cmd_q == CMD_CLR_VAL) begin
				slot_we = (slot_rd_q == val_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= in_cmd;
			id_q   <= in_store_id;
			val_q  <= in_value;
			idx_q  <= in_slot_index;
			size_q <= in_new_size;
		end
	end

	always_ff @(posedge clk) begin
		len_rd_q <= len_mem[len_ra];
		if (ctl.create_start) begin
			len_mem[IW'(made_q)] <= LW'(size_q);
		end
	end

	always_ff @(posedge clk) begin
		slot_rd_q <= slot_mem[slot_ra];
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.create_start) begin
			addr_q <= mul_base;
			sl_q   <= '0;
		end else if (ctl.clear_step) begin
			addr_q <= addr_q + AW'(1);
			sl_q   <= sl_q + LW'(1);
		end else if (ctl.poke_start) begin
			addr_q <= slot_ra;
		end else if (ctl.scan_start) begin
			addr_q    <= mul_base;
			row_q     <= mul_base;
			sl_q      <= '0;
			cur_len_q <= len_rd_q;
			cur_st_q  <= cur_st_d;
		end else if (issue_fire) begin
			if (row_end) begin
				if (more) begin
					row_q     <= row_q + SLOTS_A;
					addr_q    <= row_q + SLOTS_A;
					sl_q      <= '0;
					cur_len_q <= len_rd_q;
					cur_st_q  <= cur_st_d;
				end
			end else begin
				addr_q <= addr_q + AW'(1);
				sl_q   <= sl_q + LW'(1);
			end
		end
		addr_s1 <= addr_q;
		st_s1   <= cur_st_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
			made_q  <= '0;
		end else begin
			vld_s1 <= issue_fire;
			if (ctl.scan_start) begin
				issue_q <= 1'b1;
				found_q <= 1'b0;
			end else if (!ctl.scan_en || (issue_fire && row_end && !more)) begin
				issue_q <= 1'b0;
			end
			if (cmp_en && (cmd_q == CMD_ADD_FREE) && !found_q && (slot_rd_q == '0)) begin
				found_q <= 1'b1;
			end
			if (ctl.create_done) begin
				made_q <= made_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			status_q   <= ST_OK;
			made_res_q <= '0;
			mask_q     <= '0;
			count_q    <= '0;
		end else begin
			if (ctl.set_status) begin
				status_q <= ctl.status_code;
			end
			if (ctl.create_done) begin
				made_res_q <= ID_W'(made_q);
			end
			if (find_hit) begin
				if (count_q != '1) begin
					count_q <= count_q + COUNT_W'(1);
				end
				// Stores numbered past the mask width still count, but set no bit.
				for (int k = 0; k < MASK_W; k++) begin
					if (32'(st_s1) == k) begin
						mask_q[k] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_status      <= status_q;
			out_created_id  <= made_res_q;
			out_match_mask  <= mask_q;
			out_match_count <= count_q;
		end
	end

	always_comb begin
		stat.cmd        = cmd_q;
		stat.bad_size   = (size_q == '0) || (32'(size_q) > 32'(MAX_SLOTS));
		stat.full       = (32'(made_q) >= 32'(NUM_STORES));
		stat.bad_id     = (32'(id_q) >= 32'(made_q));
		stat.bad_index  = (32'(idx_q) >= 32'(len_rd_q));
		stat.no_stores  = (made_q == '0);
		stat.clear_last = (sl_q == LAST_SLOT);
		stat.scan_busy  = issue_q || vld_s1;
		stat.found      = found_q;
		stat.occupied   = (slot_rd_q != '0);
	end

endmodule

[sv/msst_ctrl.sv]
// Controller of the multi-store slot table: a one-hot state machine that
// takes a beat, sequences the datapath and holds the output beat valid.
// Depends on msst_pkg; drives msst_datapath through ctl_cmd_t.
module msst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  msst_pkg::dp_stat_t stat,
	output msst_pkg::ctl_cmd_t ctl
);
	import msst_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CHECK = 6'b000010,
		S_CLEAR = 6'b000100,
		S_SCAN  = 6'b001000,
		S_POKE  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_DONE;
				case (stat.cmd)
					CMD_CREATE: begin
						if (stat.bad_size) begin
							ctl.set_status  = 1'b1;
							ctl.status_code = ST_BAD_SIZE;
						end else if (stat.full) begin
							ctl.set_status  = 1'b1;
							ctl.status_code = ST_FULL;
						end else begin
							ctl.create_start = 1'b1;
							state_d          = S_CLEAR;
						end
					end
					CMD_ADD_FREE, CMD_CLR_VAL: begin
						if (stat.bad_id) begin
							ctl.set_status  = 1'b1;
							ctl.status_code = ST_BAD_ID;
						end else begin
							ctl.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					CMD_ADD_AT, CMD_CLR_AT: begin
						if (stat.bad_id) begin
							ctl.set_status  = 1'b1;
							ctl.status_code = ST_BAD_ID;
						end else if (stat.bad_index) begin
							ctl.set_status  = 1'b1;
							ctl.status_code = ST_BAD_INDEX;
						end else begin
							ctl.poke_start = 1'b1;
							state_d        = S_POKE;
						end
					end
					CMD_FIND: begin
						if (!stat.no_stores) begin
							ctl.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_CLEAR: begin
				ctl.clear_step = 1'b1;
				if (stat.clear_last) begin
					ctl.create_done = 1'b1;
					state_d         = S_DONE;
				end
			end
			S_SCAN: begin
				ctl.scan_en = 1'b1;
				if (stat.found || !stat.scan_busy) begin
					if ((stat.cmd == CMD_ADD_FREE) && !stat.found) begin
						ctl.set_status  = 1'b1;
						ctl.status_code = ST_NO_FREE;
					end
					state_d = S_DONE;
				end
			end
			S_POKE: begin
				ctl.poke_exec = 1'b1;
				if ((stat.cmd == CMD_ADD_AT) && stat.occupied) begin
					ctl.set_status  = 1'b1;
					ctl.status_code = ST_OCCUPIED;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[sv/multi_store_slot_table.sv]
// Multi-store slot table: a numbered set of stores, each a row of 32-bit
// slots where zero means empty, with create, add, clear and find commands.
// Depends on msst_pkg, msst_ctrl and msst_datapath.
//
// Usage: each command arrives as one beat on the s_ side (cmd on s_tuser,
// the other fields on s_tdata) and answers with exactly one beat on the
// m_ side carrying status, created ID, match mask and match count.
// One command is worked on at a time; s_tready is high while the block is
// idle, and a new beat is taken even while the previous answer still waits
// on the m_ side in the output register.
// From accept to m_tvalid: a command rejected by its checks or an unused
// code goes from its check straight to the answer; add or clear at an
// index reads the slot and then writes it; a create sweeps the new row to
// zero one slot a cycle; add-first-free, clear-by-value and find walk the
// slots through the scan pipeline, and the slot memory gives one read per
// cycle, so a find walks every slot of every created store, up to
// NUM_STORES * MAX_SLOTS. The next beat can be taken in the cycle after
// the answer is loaded.
// Reset empties the table (no stores exist); rows are zeroed when created.
// When the receiver stalls, the answer holds in the output register and the
// next command finishes its work and then waits until that beat is taken.
module multi_store_slot_table #(
	parameter int NUM_STORES = 8,
	parameter int MAX_SLOTS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: store_id[2:0], value[34:3], slot_index[38:35], new_size[43:39], zeros
	input  logic [47:0] s_tdata,
	// s_tuser: cmd[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: status[2:0], created_id[5:3], match_mask[13:6], match_count[21:14], zeros
	output logic [23:0] m_tdata
);
	import msst_pkg::*;

	ctl_cmd_t            ctl;
	dp_stat_t            stat;
	logic [STATUS_W-1:0] res_status;
	logic [ID_W-1:0]     res_created_id;
	logic [MASK_W-1:0]   res_match_mask;
	logic [COUNT_W-1:0]  res_match_count;

	msst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.ctl       (ctl)
	);

	msst_datapath #(
		.NUM_STORES (NUM_STORES),
		.MAX_SLOTS  (MAX_SLOTS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_cmd          (s_tuser),
		.in_store_id     (s_tdata[2:0]),
		.in_value        (s_tdata[34:3]),
		.in_slot_index   (s_tdata[38:35]),
		.in_new_size     (s_tdata[43:39]),
		.ctl             (ctl),
		.stat            (stat),
		.out_status      (res_status),
		.out_created_id  (res_created_id),
		.out_match_mask  (res_match_mask),
		.out_match_count (res_match_count)
	);

	assign m_tdata = {2'b00, res_match_count, res_match_mask, res_created_id, res_status};

endmodule
